/* hdl/dast_pkg.sv */
// Shared types and constants for the daily alarm slot table.
// Holds table size, command codes and the controller/datapath interface structs.
// No dependencies.
package dast_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int FUNC_W   = 3;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SLOTN_W  = 4;
  localparam int FOUND_W  = 4;
  localparam int TIME_W   = HOUR_W + MINUTE_W;

  localparam int IN_W  = 24;
  localparam int OUT_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_TIME = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL_SLOT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CHECK    = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic             load;     // latch incoming command, clear search
    logic             rd_en;    // read one slot time
    logic [IDX_W-1:0] rd_addr;
    logic             commit;   // apply update, load result register
  } dast_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_scan;   // incoming command needs a table scan
    logic out_free;  // result register empty or being taken
  } dast_sts_t;

endpackage

/* hdl/daily_alarm_slot_table.sv */
// Daily alarm slot table: a table of SLOTS hour/minute alarms with add,
// delete by time, delete by slot, midnight tick and check commands.
// Input: s_axis_* stream, one command per transfer.
// Output: m_axis_* stream, exactly one result transfer per command.
// Add, delete by time and check scan the table one slot per cycle through
// the time RAM read port, then pass a compare flush state and a commit
// state. The next command is taken once the previous one has committed.
// Delete by slot, tick and unused codes skip the scan and go straight to
// the commit state.
// The result sits in an output register; a new command is taken while it
// waits. If the receiver stalls, the next command stops at commit until the
// result register is free.
// Reset (rst, synchronous) frees every slot and clears every fired mark at
// once; no clearing pass is needed.
// Depends on dast_pkg, dast_ctrl, dast_datapath, dast_ram.
module daily_alarm_slot_table
  import dast_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // func[2:0], hour[7:3], minute[13:8], slot_number[17:14]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // ok[0], found_slot[4:1]
);

  dast_cmd_t cmd;
  dast_sts_t sts;

  dast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dast_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("commit while result register occupied");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_axis_tready)
    else $error("input still ready after taking a command");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (32'(cmd.rd_addr) < SLOTS))
    else $error("scan address beyond table");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.commit))
    else $error("result appeared without commit");

endmodule

/* hdl/dast_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/dast_datapath.sv */
// Datapath of the alarm table: command register, valid/fired flags, time RAM,
// scan compare stage and result register. Depends on dast_pkg and dast_ram.
module dast_datapath
  import dast_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  in_data,
  input  dast_cmd_t        cmd,
  output dast_sts_t        sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  logic [FUNC_W-1:0]   func;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SLOTN_W-1:0]  slot_number;

  logic [SLOTS-1:0]    slot_valid;
  logic [SLOTS-1:0]    slot_fired;

  logic [TIME_W-1:0]   rd_time;
  logic                cmp_pending;
  logic [IDX_W-1:0]    cmp_idx;
  logic                match_hit;
  logic [IDX_W-1:0]    match_idx;
  logic                free_hit;
  logic [IDX_W-1:0]    free_idx;

  logic                ok;
  logic [FOUND_W-1:0]  found_slot;

  logic [FUNC_W-1:0]   in_func;
  logic                add_go;
  logic [IDX_W-1:0]    del_idx;

  assign in_func = in_data[FUNC_W-1:0];
  assign sts.in_scan = (in_func == FUNC_ADD) || (in_func == FUNC_DEL_TIME) ||
                       (in_func == FUNC_CHECK);
  assign sts.out_free = !out_valid || out_ready;

  assign add_go  = cmd.commit && (func == FUNC_ADD) && !match_hit && free_hit;
  assign del_idx = IDX_W'(slot_number);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func        <= in_data[FUNC_W-1:0];
      hour        <= in_data[FUNC_W +: HOUR_W];
      minute      <= in_data[FUNC_W+HOUR_W +: MINUTE_W];
      slot_number <= in_data[FUNC_W+HOUR_W+MINUTE_W +: SLOTN_W];
    end
  end

  dast_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_time_ram (
    .clk   (clk),
    .we    (add_go),
    .waddr (free_idx),
    .wdata ({hour, minute}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_time)
  );

  // compare stage, in the cycle after the RAM read; first hit wins
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pending <= 1'b0;
    end else begin
      cmp_pending <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cmp_idx <= cmd.rd_addr;
    end
    if (cmd.load) begin
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else if (cmp_pending) begin
      if (slot_valid[cmp_idx] && (rd_time == {hour, minute}) && !match_hit) begin
        match_hit <= 1'b1;
        match_idx <= cmp_idx;
      end
      if (!slot_valid[cmp_idx] && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
  end

  // table flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_fired <= '0;
      out_valid  <= 1'b0;
    end else if (cmd.commit) begin
      out_valid  <= 1'b1;
      ok         <= 1'b0;
      found_slot <= '0;
      case (func)
        FUNC_ADD: begin
          if (!match_hit && free_hit) begin
            slot_valid[free_idx] <= 1'b1;
            slot_fired[free_idx] <= 1'b0;
            ok <= 1'b1;
          end
        end
        FUNC_DEL_TIME: begin
          if (match_hit) begin
            slot_valid[match_idx] <= 1'b0;
            ok <= 1'b1;
          end
        end
        FUNC_DEL_SLOT: begin
          if (32'(slot_number) < SLOTS) begin
            slot_valid[del_idx] <= 1'b0;
          end
        end
        FUNC_TICK: begin
          if ((hour == '0) && (minute == '0)) begin
            slot_fired <= '0;
          end
        end
        FUNC_CHECK: begin
          if (match_hit && !slot_fired[match_idx]) begin
            slot_fired[match_idx] <= 1'b1;
            ok         <= 1'b1;
            found_slot <= FOUND_W'(match_idx);
          end
        end
        default: begin
        end
      endcase
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {{(OUT_W-1-FOUND_W){1'b0}}, found_slot, ok};

endmodule

/* hdl/dast_ctrl.sv */
// Controller of the alarm table: accept, slot scan sequencing and commit.
// Depends on dast_pkg.
module dast_ctrl
  import dast_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output dast_cmd_t cmd,
  input  dast_sts_t sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] scan_cnt;
  logic [IDX_W-1:0] scan_cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    cmd.load      = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_addr   = scan_cnt;
    cmd.commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          scan_cnt_next = '0;
          state_next    = sts.in_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_cnt == IDX_W'(SLOTS - 1)) begin
          state_next = ST_FLUSH;
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end
      ST_FLUSH: begin
        // last slot is compared in this cycle
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
    end
  end

endmodule
